[design/second_order_lowpass_filter_defines.svh]
// Assertion macros used by the second-order low-pass filter top-level design file.
`ifndef SECOND_ORDER_LOWPASS_FILTER_DEFINES_SVH
`define SECOND_ORDER_LOWPASS_FILTER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SLPF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SLPF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define SLPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/slpf_pkg.sv]
// Types and constants shared by the second-order low-pass filter modules.
package slpf_pkg;

	// Sample and coefficient formats: Q16.16 samples, Q2.30 coefficients.
	localparam int SAMPLE_W  = 32;
	localparam int COEF_W    = 32;
	localparam int COEF_FRAC = 30;

	// Tap sum x + 2*x1 + x2 needs two extra bits plus one of margin.
	localparam int TAP_W = SAMPLE_W + 3;
	// Feed-forward and feedback product widths.
	localparam int FF_W  = COEF_W + TAP_W;
	localparam int FB_W  = COEF_W + SAMPLE_W;
	// Accumulator holds the sum of three products without overflow.
	localparam int ACC_W = FF_W + 2;

	// Number of samples that bypass the filter after reset.
	localparam logic [1:0] STARTUP_LEN = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN = 2'd0,
		CFG_FB1  = 2'd1,
		CFG_FB2  = 2'd2
	} cfg_idx_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	// Coefficient set as loaded by software.
	typedef struct packed {
		coef_t gain;
		coef_t fb1;
		coef_t fb2;
	} coef_set_t;

	// Filter history: two past inputs and two past outputs.
	typedef struct packed {
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} hist_t;

endpackage

[design/slpf_if.sv]
// Stream interfaces for the filter's sample input and result output channels.
interface slpf_in_if;
	logic                    valid;
	logic                    ready;
	logic signed [slpf_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface slpf_out_if;
	logic                    valid;
	logic                    ready;
	logic signed [slpf_pkg::SAMPLE_W-1:0] filtered_sample;
	logic                    warming_up;

	modport source (output valid, output filtered_sample, output warming_up, input ready);
	modport sink (input valid, input filtered_sample, input warming_up, output ready);
endinterface

[design/second_order_lowpass_filter.sv]
// Second-order IIR low-pass filter: top level with input stage, history and result register.
// Takes one Q16.16 sample per beat and returns one filtered sample per beat, computing
// y = A*x + 2A*x1 + A*x2 + D*y1 + E*y2 with A, D and E loaded as Q2.30 coefficients, rounded
// half up and saturated to the 32-bit sample range. The first two samples after reset pass
// through unchanged with warming_up set. Throughput is one sample per clock cycle unless
// results.ready stalls; a beat passes the input register, then the result register. The
// output-feedback path via the multiply-add into the previous-output register sets the cycle
// time. The user must write coefficients via wr_en/wr_index/wr_data only while the filter is idle; unenforced.
`include "second_order_lowpass_filter_defines.svh"

module second_order_lowpass_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [slpf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [slpf_pkg::COEF_W-1:0]    wr_data,
	slpf_in_if.sink                        samples,
	slpf_out_if.source                     results
);

	slpf_pkg::coef_set_t coefs;
	slpf_pkg::hist_t     hist;
	slpf_pkg::sample_t   kernel_y;
	slpf_pkg::sample_t   next_y;

	slpf_pkg::sample_t   sample_s1;
	logic                valid_s1;

	slpf_pkg::sample_t   x1_q;
	slpf_pkg::sample_t   x2_q;
	slpf_pkg::sample_t   y1_q;
	slpf_pkg::sample_t   y2_q;
	logic [1:0]          startup_q;

	slpf_pkg::sample_t   out_sample_q;
	logic                out_warm_q;
	logic                out_valid_q;

	logic                advance;
	logic                warm;

	// Coefficient registers.
	slpf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.coefs    (coefs)
	);

	// Filter arithmetic on the registered sample and the current history.
	assign hist = '{x1: x1_q, x2: x2_q, y1: y1_q, y2: y2_q};

	slpf_kernel u_kernel (
		.x     (sample_s1),
		.hist  (hist),
		.coefs (coefs),
		.y     (kernel_y)
	);

	// The input stage moves on whenever the result register is free or being emptied.
	assign advance       = valid_s1 && (!out_valid_q || results.ready);
	assign samples.ready = !valid_s1 || advance;

	// During start-up the sample bypasses the filter.
	assign warm   = (startup_q < slpf_pkg::STARTUP_LEN);
	assign next_y = warm ? sample_s1 : kernel_y;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.valid && samples.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= samples.sample_in;
		end
	end

	// History and start-up counter, updated as each sample completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q      <= '0;
			x2_q      <= '0;
			y1_q      <= '0;
			y2_q      <= '0;
			startup_q <= '0;
		end else if (advance) begin
			x1_q <= sample_s1;
			x2_q <= x1_q;
			y1_q <= next_y;
			y2_q <= y1_q;
			if (warm) begin
				startup_q <= startup_q + 2'd1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_sample_q <= next_y;
			out_warm_q   <= warm;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.filtered_sample = out_sample_q;
	assign results.warming_up      = out_warm_q;

	// Checks on the stage and history bookkeeping.
	`SLPF_ASSERT_IMPLY(a_out_is_last_y, out_valid_q, out_sample_q == y1_q, "result differs from output history")
	`SLPF_ASSERT_IMPLY(a_warm_passes_x, out_valid_q && out_warm_q, out_sample_q == x1_q, "bypassed result is not the input sample")
	`SLPF_ASSERT_ALWAYS(a_startup_bound, startup_q <= slpf_pkg::STARTUP_LEN, "start-up counter overran")
	`SLPF_ASSERT_NEXT(a_stage_drains, valid_s1 && !out_valid_q, out_valid_q, "input stage did not move to a free result register")
	`SLPF_ASSERT_IMPLY(a_empty_stage_ready, !valid_s1, samples.ready, "empty input stage refuses a beat")

endmodule

[design/slpf_cfg.sv]
// Coefficient register bank written through the plain configuration port.
module slpf_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [slpf_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [slpf_pkg::COEF_W-1:0]        wr_data,
	output slpf_pkg::coef_set_t                coefs
);

	slpf_pkg::coef_set_t coefs_q;

	// Decode the register index; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				slpf_pkg::CFG_GAIN: begin
					coefs_q.gain <= $signed(wr_data);
				end
				slpf_pkg::CFG_FB1: begin
					coefs_q.fb1 <= $signed(wr_data);
				end
				slpf_pkg::CFG_FB2: begin
					coefs_q.fb2 <= $signed(wr_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

[design/slpf_kernel.sv]
// Multiply-accumulate, rounding and saturation for one filter output.
module slpf_kernel (
	input  slpf_pkg::sample_t   x,
	input  slpf_pkg::hist_t     hist,
	input  slpf_pkg::coef_set_t coefs,
	output slpf_pkg::sample_t   y
);

	localparam int ACC_W = slpf_pkg::ACC_W;
	localparam int HI_W  = ACC_W - slpf_pkg::SAMPLE_W + 1;
	localparam logic signed [ACC_W-1:0] ROUND_HALF =
		ACC_W'(1) <<< (slpf_pkg::COEF_FRAC - 1);

	logic signed [slpf_pkg::TAP_W-1:0] tap_sum;
	logic signed [slpf_pkg::FF_W-1:0]  prod_ff;
	logic signed [slpf_pkg::FB_W-1:0]  prod_fb1;
	logic signed [slpf_pkg::FB_W-1:0]  prod_fb2;
	logic signed [ACC_W-1:0]           acc;
	logic signed [ACC_W-1:0]           scaled;
	logic [HI_W-1:0]                   scaled_hi;

	// The three feed-forward taps share A, so they are summed before the multiply.
	assign tap_sum = slpf_pkg::TAP_W'(x) + (slpf_pkg::TAP_W'(hist.x1) <<< 1)
		+ slpf_pkg::TAP_W'(hist.x2);

	// Three products in parallel.
	assign prod_ff  = slpf_pkg::FF_W'(coefs.gain) * slpf_pkg::FF_W'(tap_sum);
	assign prod_fb1 = slpf_pkg::FB_W'(coefs.fb1) * slpf_pkg::FB_W'(hist.y1);
	assign prod_fb2 = slpf_pkg::FB_W'(coefs.fb2) * slpf_pkg::FB_W'(hist.y2);

	// Exact sum, then round half up and drop the coefficient fraction.
	assign acc    = ACC_W'(prod_ff) + ACC_W'(prod_fb1) + ACC_W'(prod_fb2) + ROUND_HALF;
	assign scaled = acc >>> slpf_pkg::COEF_FRAC;
	assign scaled_hi = scaled[ACC_W-1:slpf_pkg::SAMPLE_W-1];

	// Saturate when the upper bits are not all copies of the sign.
	always_comb begin
		if ((scaled_hi == '0) || (scaled_hi == '1)) begin
			y = scaled[slpf_pkg::SAMPLE_W-1:0];
		end else if (scaled[ACC_W-1]) begin
			y = {1'b1, {(slpf_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			y = {1'b0, {(slpf_pkg::SAMPLE_W-1){1'b1}}};
		end
	end

endmodule
